// ----- sv/dabd_pkg.sv -----
// Shared types, constants and register codes for the detection argmax box decoder.
package dabd_pkg;

    localparam int unsigned MAX_CLASSES_DEF = 80;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned CFG_DATA_W      = 24;

    localparam logic [14:0] CONF_THR_RST  = 15'd8192;
    localparam logic [7:0]  ACTIVE_RST    = 8'd80;
    localparam logic [23:0] INV_RATIO_RST = 24'd65536;
    localparam logic [11:0] PAD_RST       = 12'd0;
    localparam logic [13:0] IMG_SIZE_RST  = 14'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONF_THR  = 3'd0,
        CFG_ACTIVE    = 3'd1,
        CFG_INV_RATIO = 3'd2,
        CFG_PAD_X     = 3'd3,
        CFG_PAD_Y     = 3'd4,
        CFG_IMG_W     = 3'd5,
        CFG_IMG_H     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [14:0] score_thr;
        logic [7:0]  class_limit;
        logic [23:0] inv_ratio;
        logic [11:0] pad_x;
        logic [11:0] pad_y;
        logic [13:0] image_width;
        logic [13:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        center_x;
        logic [15:0]        center_y;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic signed [15:0] score;
        logic [7:0]         cls_idx;
    } t_job;

endpackage

// ----- sv/dabd_front.sv -----
// Front end: holds the anchor box, runs the class argmax and issues decode jobs.
module dabd_front #(
    parameter int unsigned MAX_CLASSES = dabd_pkg::MAX_CLASSES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_kind,
    input  logic [15:0]         i_center_x,
    input  logic [15:0]         i_center_y,
    input  logic [15:0]         i_box_width,
    input  logic [15:0]         i_box_height,
    input  logic signed [15:0]  i_score,
    input  logic                i_last_score,
    input  dabd_pkg::t_cfg      i_cfg,
    output logic                o_push,
    output dabd_pkg::t_job      o_job
);

    localparam logic [7:0] MaxCls = 8'(MAX_CLASSES);

    logic [15:0]        r_cx, r_cy, r_w, r_h;
    logic [15:0]        n_cx, n_cy, n_w, n_h;
    logic signed [15:0] r_best, n_best;
    logic [7:0]         r_cls, n_cls;
    logic               r_found, n_found;
    logic [7:0]         r_cnt, n_cnt;
    logic               n_push;

    always_comb begin
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_w     = r_w;
        n_h     = r_h;
        n_best  = r_best;
        n_cls   = r_cls;
        n_found = r_found;
        n_cnt   = r_cnt;
        n_push  = 1'b0;
        if (i_accept) begin
            if (!i_kind) begin
                n_cx    = i_center_x;
                n_cy    = i_center_y;
                n_w     = i_box_width;
                n_h     = i_box_height;
                n_best  = 16'sh8000;
                n_cls   = 8'd0;
                n_found = 1'b0;
                n_cnt   = 8'd0;
            end else begin
                if (r_cnt < MaxCls && i_score > r_best) begin
                    n_best  = i_score;
                    n_cls   = r_cnt;
                    n_found = 1'b1;
                end
                if (r_cnt != 8'hFF) begin
                    n_cnt = r_cnt + 8'd1;
                end
                if (i_last_score) begin
                    n_push = n_found
                        && n_best > $signed({1'b0, i_cfg.score_thr})
                        && n_cls < i_cfg.class_limit;
                    n_best  = 16'sh8000;
                    n_cls   = 8'd0;
                    n_found = 1'b0;
                    n_cnt   = 8'd0;
                end
            end
        end
    end

    always_comb begin
        o_push           = n_push;
        o_job.center_x   = r_cx;
        o_job.center_y   = r_cy;
        o_job.box_width  = r_w;
        o_job.box_height = r_h;
        o_job.score      = (r_cnt < MaxCls && i_score > r_best) ? i_score : r_best;
        o_job.cls_idx    = (r_cnt < MaxCls && i_score > r_best) ? r_cnt : r_cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_best  <= 16'sh8000;
            r_cls   <= '0;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_w     <= n_w;
            r_h     <= n_h;
            r_best  <= n_best;
            r_cls   <= n_cls;
            r_found <= n_found;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- sv/dabd_fifo.sv -----
// Short job queue between the argmax front end and the box decode back end.
module dabd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dabd_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_nonempty,
    output logic           o_full,
    output dabd_pkg::t_job o_job
);

    localparam int unsigned Depth = dabd_pkg::QUEUE_DEPTH;
    localparam int unsigned PtrW  = $clog2(Depth);
    localparam int unsigned CntW  = $clog2(Depth + 1);

    dabd_pkg::t_job  r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_nonempty = (r_cnt != '0);
    assign o_full     = (r_cnt == CntW'(Depth));
    assign o_job      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + PtrW'(1);
            end
            r_cnt <= r_cnt + CntW'(i_push) - CntW'(i_pop);
        end
    end

endmodule

// ----- sv/dabd_back.sv -----
// Back end: three-stage elastic pipeline that turns a job into clamped corner coordinates.
module dabd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dabd_pkg::t_cfg     i_cfg,
    input  logic               i_job_valid,
    input  dabd_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [19:0] o_left,
    output logic signed [19:0] o_top,
    output logic signed [19:0] o_right,
    output logic signed [19:0] o_bottom,
    output logic signed [15:0] o_best_score_out,
    output logic [7:0]         o_class_id
);

    localparam logic signed [43:0] OutMax = 44'sd524287;
    localparam logic signed [43:0] OutMin = -44'sd524288;
    localparam logic signed [43:0] RndOfs = 44'sd65536;

    logic               r_v1, r_v2, r_v3;
    logic               adv1, adv2, adv3;
    logic signed [18:0] r_d [4];
    logic signed [18:0] n_d [4];
    logic signed [43:0] r_p [4];
    logic signed [19:0] r_o [4];
    logic signed [19:0] n_o [4];
    logic signed [15:0] r_sc1, r_sc2, r_sc3;
    logic [7:0]         r_cl1, r_cl2, r_cl3;

    logic signed [18:0] cx2, cy2, w, h, px, py;
    logic signed [43:0] t;
    logic signed [43:0] lim_x, lim_y, lim;

    assign adv3  = !r_v3 || !i_stall;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    assign o_pop = i_job_valid && adv1;

    always_comb begin
        cx2    = $signed({2'b00, i_job.center_x, 1'b0});
        cy2    = $signed({2'b00, i_job.center_y, 1'b0});
        w      = $signed({3'b000, i_job.box_width});
        h      = $signed({3'b000, i_job.box_height});
        px     = $signed({2'b00, i_cfg.pad_x, 5'b00000});
        py     = $signed({2'b00, i_cfg.pad_y, 5'b00000});
        n_d[0] = cx2 - w - px;
        n_d[1] = cy2 - h - py;
        n_d[2] = cx2 + w - px;
        n_d[3] = cy2 + h - py;
    end

    always_comb begin
        lim_x = $signed({26'd0, i_cfg.image_width, 4'd0});
        lim_y = $signed({26'd0, i_cfg.image_height, 4'd0});
        lim   = '0;
        t     = '0;
        for (int k = 0; k < 4; k++) begin
            t = (r_p[k] + RndOfs) >>> 17;
            if (k < 2) begin
                if (t < 44'sd0) begin
                    t = 44'sd0;
                end else if (t > OutMax) begin
                    t = OutMax;
                end
            end else begin
                lim = (k == 2) ? lim_x : lim_y;
                if (t > lim) begin
                    t = lim;
                end else if (t < OutMin) begin
                    t = OutMin;
                end
            end
            n_o[k] = t[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_d   <= n_d;
            r_sc1 <= i_job.score;
            r_cl1 <= i_job.cls_idx;
        end
        if (adv2) begin
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= r_d[k] * $signed({1'b0, i_cfg.inv_ratio});
            end
            r_sc2 <= r_sc1;
            r_cl2 <= r_cl1;
        end
        if (adv3) begin
            r_o   <= n_o;
            r_sc3 <= r_sc2;
            r_cl3 <= r_cl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_job_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_valid          = r_v3;
    assign o_left           = r_o[0];
    assign o_top            = r_o[1];
    assign o_right          = r_o[2];
    assign o_bottom         = r_o[3];
    assign o_best_score_out = r_sc3;
    assign o_class_id       = r_cl3;

endmodule

// ----- sv/detection_argmax_box_decode.sv -----
// Top level: configuration registers, argmax front end, job queue and box decode back end.
// Throughput: one item per cycle, box and score items alike, while the job queue is not full.
// A detection is written to the job queue when its last score item is accepted, then passes the three decode stages.
// The 4-entry job queue and 3-stage decode pipeline absorb output stalls; input stalls
// only once the queue is full.
// Synchronous active-low reset restores register defaults and empties queue and pipeline.
module detection_argmax_box_decode #(
    parameter int unsigned MAX_CLASSES = dabd_pkg::MAX_CLASSES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [dabd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dabd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic [15:0]                       i_center_x,
    input  logic [15:0]                       i_center_y,
    input  logic [15:0]                       i_box_width,
    input  logic [15:0]                       i_box_height,
    input  logic signed [15:0]                i_score,
    input  logic                              i_last_score,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [19:0]                o_left,
    output logic signed [19:0]                o_top,
    output logic signed [19:0]                o_right,
    output logic signed [19:0]                o_bottom,
    output logic signed [15:0]                o_best_score_out,
    output logic [7:0]                        o_class_id
);

    dabd_pkg::t_cfg r_cfg;
    dabd_pkg::t_job front_job, queue_job;
    logic           accept, push, pop, q_nonempty, q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_thr      <= dabd_pkg::CONF_THR_RST;
            r_cfg.class_limit    <= dabd_pkg::ACTIVE_RST;
            r_cfg.inv_ratio      <= dabd_pkg::INV_RATIO_RST;
            r_cfg.pad_x          <= dabd_pkg::PAD_RST;
            r_cfg.pad_y          <= dabd_pkg::PAD_RST;
            r_cfg.image_width    <= dabd_pkg::IMG_SIZE_RST;
            r_cfg.image_height   <= dabd_pkg::IMG_SIZE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dabd_pkg::CFG_CONF_THR:  r_cfg.score_thr      <= i_cfg_data[14:0];
                dabd_pkg::CFG_ACTIVE:    r_cfg.class_limit    <= i_cfg_data[7:0];
                dabd_pkg::CFG_INV_RATIO: r_cfg.inv_ratio      <= i_cfg_data[23:0];
                dabd_pkg::CFG_PAD_X:     r_cfg.pad_x          <= i_cfg_data[11:0];
                dabd_pkg::CFG_PAD_Y:     r_cfg.pad_y          <= i_cfg_data[11:0];
                dabd_pkg::CFG_IMG_W:     r_cfg.image_width    <= i_cfg_data[13:0];
                dabd_pkg::CFG_IMG_H:     r_cfg.image_height   <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    dabd_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_score      (i_score),
        .i_last_score (i_last_score),
        .i_cfg        (r_cfg),
        .o_push       (push),
        .o_job        (front_job)
    );

    dabd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (front_job),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_full     (q_full),
        .o_job      (queue_job)
    );

    dabd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_job_valid      (q_nonempty),
        .i_job            (queue_job),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_left           (o_left),
        .o_top            (o_top),
        .o_right          (o_right),
        .o_bottom         (o_bottom),
        .o_best_score_out (o_best_score_out),
        .o_class_id       (o_class_id)
    );

endmodule

// ----- sv/dabd_chk.sv -----
// Port-level checks for the detection argmax box decoder, bound to the top level.
module dabd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [19:0] o_left,
    input logic signed [19:0] o_top,
    input logic signed [15:0] o_best_score_out,
    input logic [7:0]         o_class_id
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_left[19] && !o_top[19])
        else $error("left or top below zero");

    a_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_best_score_out[15] && o_best_score_out != 16'sd0
            && o_class_id != 8'hFF)
        else $error("emitted score or class out of range");

endmodule

bind detection_argmax_box_decode dabd_chk u_dabd_chk (.*);
